// ----- hdl/kwscan_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kwscan_pkg - shared types and constants of the keyword/integer scanner
// Holds the phase and status codes, the key bytes and the scanner state record.
// ----------------------------------------------------------------------------
package kwscan_pkg;

    localparam int KEY_LEN = 7;
    localparam int KEY_IDX_W = 3;
    localparam int MAG_W = 31;
    localparam int VALUE_W = 32;
    localparam int STATUS_W = 2;
    localparam int BYTE_W = 8;
    localparam int OUT_TDATA_W = 40;
    localparam int PROD_W = 35;

    localparam logic [PROD_W-1:0] MAG_LIMIT = PROD_W'(32'h7fff_ffff);

    // key "return "
    localparam logic [BYTE_W-1:0] KEY_BYTES [KEY_LEN] = '{
        8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6e, 8'h20
    };
    // matched length after which a mismatch on "e" falls back to two matched bytes
    localparam logic [KEY_IDX_W-1:0] KEY_OVERLAP_LEN = 3'd5;

    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_VT    = 8'h0b;
    localparam logic [BYTE_W-1:0] CH_FF    = 8'h0c;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2b;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        PH_SEARCH = 3'd0,
        PH_LEAD   = 3'd1,
        PH_SIGN   = 3'd2,
        PH_DIGITS = 3'd3,
        PH_TRAIL  = 3'd4,
        PH_BAD    = 3'd5,
        PH_DONE   = 3'd6
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_NO_KEY = 2'd1,
        ST_BAD    = 2'd2
    } status_t;

    typedef struct packed {
        phase_t                 phase;
        logic [KEY_IDX_W-1:0]   key_len;
        logic                   negative;
        logic [MAG_W-1:0]       magnitude;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        phase:     PH_SEARCH,
        key_len:   '0,
        negative:  1'b0,
        magnitude: '0
    };

endpackage
`default_nettype wire

// ----- hdl/keyword_then_int_literal_scanner_core.sv -----
`default_nettype none
// The final byte passes the input register and the state update; the result register
//   then loads, and the result is offered on m_tvalid until it is taken.
// Throughput: one text byte per cycle unless the input is stalled; the state update is a single pass.
// A pending result stalls the input only when another final byte arrives.
// Reset (aresetn low, synchronous) drops all held requests and restarts the
//   key search for a new text.
// ----------------------------------------------------------------------------
// keyword_then_int_literal_scanner_core - "return <integer>" scanner
// Searches a byte stream for the key "return ", parses the decimal literal
// on the rest of that line and reports status and value on the final byte.
// ----------------------------------------------------------------------------
module keyword_then_int_literal_scanner_core
    import kwscan_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [BYTE_W-1:0]       s_tdata,   // [7:0] text_byte
    input  wire logic                    s_tlast,   // end_of_text
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [OUT_TDATA_W-1:0]       m_tdata    // [1:0] status, [33:2] value
);

    logic                 in_valid_reg;
    logic [BYTE_W-1:0]    in_byte_reg;
    logic                 in_last_reg;
    scan_state_t          state_reg;
    scan_state_t          state_next;
    scan_state_t          upd_state;
    logic                 out_valid_reg;
    status_t              out_status_reg;
    status_t              status_next;
    logic [VALUE_W-1:0]   out_value_reg;
    logic [VALUE_W-1:0]   value_next;
    logic                 fire;

    // process the held byte unless it produces a result with nowhere to go
    assign fire     = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    kwscan_update u_update (
        .cur_state (state_reg),
        .text_byte (in_byte_reg),
        .nxt_state (upd_state)
    );

    // form the result from the updated state, restart after the final byte
    always_comb begin
        value_next = '0;
        if (upd_state.phase == PH_SEARCH) begin
            status_next = ST_NO_KEY;
        end else if (upd_state.phase == PH_DIGITS || upd_state.phase == PH_TRAIL
                     || upd_state.phase == PH_DONE) begin
            status_next = ST_OK;
            value_next  = upd_state.negative ? (VALUE_W'(0) - VALUE_W'(upd_state.magnitude))
                                             : VALUE_W'(upd_state.magnitude);
        end else begin
            status_next = ST_BAD;
        end
        if (!fire) begin
            state_next = state_reg;
        end else if (in_last_reg) begin
            state_next = SCAN_RESET;
        end else begin
            state_next = upd_state;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SCAN_RESET;
        end else begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (fire && in_last_reg) begin
            out_status_reg <= status_next;
            out_value_reg  <= value_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - VALUE_W - STATUS_W)'(0), out_value_reg, out_status_reg};

    // value is zero unless the literal parsed
    a_value_zero_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_status_reg != ST_OK |-> out_value_reg == '0)
        else $error("nonzero value with error status");

    // the final byte restarts the search
    a_restart_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_last_reg |=> state_reg.phase == PH_SEARCH && state_reg.key_len == '0
                                && state_reg.magnitude == '0)
        else $error("state not restarted after final byte");

    // the key match never reaches the full key length while searching
    a_key_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.key_len != KEY_IDX_W'(KEY_LEN))
        else $error("key match length out of range");

    // a stalled result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |-> !(fire && in_last_reg))
        else $error("pending result overwritten");

endmodule
`default_nettype wire

// ----- hdl/kwscan_update.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kwscan_update - next-state logic of the scanner for one text byte
// Runs the overlapping key search, then the tail parser with the
// multiply-by-ten accumulator and its overflow check.
// ----------------------------------------------------------------------------
module kwscan_update
    import kwscan_pkg::*;
(
    input  wire scan_state_t        cur_state,
    input  wire logic [BYTE_W-1:0]  text_byte,
    output scan_state_t             nxt_state
);

    logic                 is_eol;
    logic                 is_blank;
    logic                 is_digit;
    logic [PROD_W-1:0]    mag_ext;
    logic [PROD_W-1:0]    prod;
    logic                 overflow;
    logic [KEY_IDX_W:0]   key_next;

    // classify the byte
    always_comb begin
        is_eol   = (text_byte == CH_LF) || (text_byte == CH_CR);
        is_blank = text_byte inside {CH_SPACE, CH_TAB, CH_VT, CH_FF};
        is_digit = text_byte inside {[CH_ZERO:CH_NINE]};
    end

    // magnitude * 10 + digit as shift-add, overflow against the limit
    always_comb begin
        mag_ext  = PROD_W'(cur_state.magnitude);
        prod     = (mag_ext << 3) + (mag_ext << 1)
                 + PROD_W'(text_byte - CH_ZERO);
        overflow = prod > MAG_LIMIT;
    end

    // advance the key match, fall back on a mismatch
    always_comb begin
        if (text_byte == KEY_BYTES[cur_state.key_len]) begin
            key_next = {1'b0, cur_state.key_len} + 1'b1;
        end else if (cur_state.key_len == KEY_OVERLAP_LEN && text_byte == KEY_BYTES[1]) begin
            key_next = 4'd2;
        end else if (text_byte == KEY_BYTES[0]) begin
            key_next = 4'd1;
        end else begin
            key_next = '0;
        end
    end

    // phase transitions
    always_comb begin
        nxt_state = cur_state;
        case (cur_state.phase)
            PH_SEARCH: begin
                if (key_next == (KEY_IDX_W+1)'(KEY_LEN)) begin
                    nxt_state.phase   = PH_LEAD;
                    nxt_state.key_len = '0;
                end else begin
                    nxt_state.key_len = key_next[KEY_IDX_W-1:0];
                end
            end
            PH_LEAD: begin
                if (is_eol) begin
                    nxt_state.phase = PH_BAD;
                end else if (is_blank) begin
                    nxt_state.phase = PH_LEAD;
                end else if (text_byte == CH_PLUS || text_byte == CH_MINUS) begin
                    nxt_state.negative = (text_byte == CH_MINUS);
                    nxt_state.phase    = PH_SIGN;
                end else if (is_digit) begin
                    if (overflow) begin
                        nxt_state.phase = PH_BAD;
                    end else begin
                        nxt_state.magnitude = prod[MAG_W-1:0];
                        nxt_state.phase     = PH_DIGITS;
                    end
                end else begin
                    nxt_state.phase = PH_BAD;
                end
            end
            PH_SIGN, PH_DIGITS: begin
                if (cur_state.phase == PH_DIGITS && is_eol) begin
                    nxt_state.phase = PH_DONE;
                end else if (is_digit) begin
                    if (overflow) begin
                        nxt_state.phase = PH_BAD;
                    end else begin
                        nxt_state.magnitude = prod[MAG_W-1:0];
                        nxt_state.phase     = PH_DIGITS;
                    end
                end else if (cur_state.phase == PH_DIGITS && is_blank) begin
                    nxt_state.phase = PH_TRAIL;
                end else begin
                    nxt_state.phase = PH_BAD;
                end
            end
            PH_TRAIL: begin
                if (is_eol) begin
                    nxt_state.phase = PH_DONE;
                end else if (!is_blank) begin
                    nxt_state.phase = PH_BAD;
                end
            end
            default: begin
                nxt_state = cur_state;
            end
        endcase
    end

endmodule
`default_nettype wire
